// ===== sv/canrx_pkg.sv =====
// Shared types and codes for the CAN receive mailbox.
package canrx_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ELAPSED_W = 17;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    localparam logic [2:0] MODE_ARRIVE  = 3'd0;
    localparam logic [2:0] MODE_REQUEST = 3'd1;
    localparam logic [2:0] MODE_TICK    = 3'd2;
    localparam logic [2:0] MODE_QUERY   = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;

    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_TIMEOUT = 2'd1;
    localparam logic [1:0] KIND_AVAIL   = 2'd2;

    typedef struct packed {
        logic [31:0] id;
        logic [3:0]  len;
        logic [63:0] data;
    } frame_t;

    localparam frame_t FRAME_ZERO = '{id: 32'd0, len: 4'd0, data: 64'd0};

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clr_one;
        logic clr_all;
    } slot_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

// ===== sv/canrx_in_if.sv =====
// Request channel of the CAN receive mailbox.
interface canrx_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [31:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic [31:0] want_id;
    logic [31:0] want_mask;
    logic [15:0] wait_ticks;

    modport source (
        output valid, mode, frame_id, frame_len, frame_data, want_id, want_mask, wait_ticks,
        input  ready
    );
    modport sink (
        input  valid, mode, frame_id, frame_len, frame_data, want_id, want_mask, wait_ticks,
        output ready
    );
endinterface

// ===== sv/canrx_out_if.sv =====
// Result channel of the CAN receive mailbox.
interface canrx_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] out_id;
    logic [3:0]  out_len;
    logic [63:0] out_data;
    logic        present;

    modport source (
        output valid, kind, out_id, out_len, out_data, present,
        input  ready
    );
    modport sink (
        input  valid, kind, out_id, out_len, out_data, present,
        output ready
    );
endinterface

// ===== sv/can_receive_mailbox_with_filter.sv =====
// CAN receive mailbox: slot ring with masked-id requests and timeouts.
//
// cmd carries one request per handshake (valid/ready): frame arrival, read
// request, 1 ms tick, availability query or clear. rsp returns at most one
// result per request: a frame, a timeout marker or an availability answer.
// cmd.ready is high only while no request is in work; a finished result sits
// in the rsp register and the next request is taken while it waits.
// Arrival, tick and clear need no scan. An arrival that satisfies the
// pending read and a tick that expires it hand their result through the
// res register to the rsp register. Read and query scan the slot memory
// one slot per cycle through its single read port, starting at the write
// pointer: a match ends the scan early; a read with no match turns pending
// once every slot has been checked, and returns nothing.
// Reset empties all slots at once (valid flags in flops), zeroes the write
// pointer and drops any pending read. While rsp is stalled, a finished
// result holds in place and the block waits before producing the next one.
module can_receive_mailbox_with_filter #(
    parameter int QUEUE_DEPTH = canrx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    canrx_in_if.sink   cmd,
    canrx_out_if.source rsp
);
    import canrx_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] SCAN_LEN  = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] SCAN_LAST = CW'(QUEUE_DEPTH - 1);

    state_t                state_reg, state_next;
    logic [AW-1:0]         write_slot_reg, write_slot_next;
    logic                  waiting_reg, waiting_next;
    logic [31:0]           pending_id_reg, pending_id_next;
    logic [31:0]           pending_mask_reg, pending_mask_next;
    logic [15:0]           pending_limit_reg, pending_limit_next;
    logic [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic [AW-1:0]         issue_addr_reg, issue_addr_next;
    logic [CW-1:0]         issue_cnt_reg, issue_cnt_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [AW-1:0]         chk_addr_reg, chk_addr_next;
    logic                  chk_last_reg, chk_last_next;
    logic                  query_reg, query_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic [31:0]           want_id_reg, want_id_next;
    logic [31:0]           want_mask_reg, want_mask_next;
    logic [15:0]           timeout_reg, timeout_next;
    logic [1:0]            res_kind_reg, res_kind_next;
    frame_t                res_frame_reg, res_frame_next;
    logic                  res_present_reg, res_present_next;
    logic [1:0]            rsp_kind_reg, rsp_kind_next;
    frame_t                rsp_frame_reg, rsp_frame_next;
    logic                  rsp_present_reg, rsp_present_next;

    slot_ctrl_t            ctrl;
    frame_t                in_frame;
    frame_t                rd_frame;
    logic                  slot_valid;
    logic                  scan_hit;
    logic                  arrive_hit;
    logic [ELAPSED_W-1:0]  elapsed_inc;

    canrx_slot_store #(.DEPTH(QUEUE_DEPTH)) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .wr_addr   (write_slot_reg),
        .wr_frame  (in_frame),
        .rd_addr   (issue_addr_reg),
        .rd_frame  (rd_frame),
        .chk_addr  (chk_addr_reg),
        .chk_valid (slot_valid)
    );

    assign in_frame    = '{id: cmd.frame_id, len: cmd.frame_len, data: cmd.frame_data};
    assign arrive_hit  = waiting_reg && ((cmd.frame_id & pending_mask_reg) == pending_id_reg);
    assign scan_hit    = chk_valid_reg && slot_valid
                         && ((rd_frame.id & want_mask_reg) == want_id_reg);
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                      : elapsed_reg + 1'b1;

    assign cmd.ready    = (state_reg == ST_IDLE);
    assign rsp.valid    = rsp_valid_reg;
    assign rsp.kind     = rsp_kind_reg;
    assign rsp.out_id   = rsp_frame_reg.id;
    assign rsp.out_len  = rsp_frame_reg.len;
    assign rsp.out_data = rsp_frame_reg.data;
    assign rsp.present  = rsp_present_reg;

    always_comb
    begin
        state_next         = state_reg;
        write_slot_next    = write_slot_reg;
        waiting_next       = waiting_reg;
        pending_id_next    = pending_id_reg;
        pending_mask_next  = pending_mask_reg;
        pending_limit_next = pending_limit_reg;
        elapsed_next       = elapsed_reg;
        issue_addr_next    = issue_addr_reg;
        issue_cnt_next     = issue_cnt_reg;
        chk_valid_next     = 1'b0;
        chk_addr_next      = chk_addr_reg;
        chk_last_next      = chk_last_reg;
        query_next         = query_reg;
        want_id_next       = want_id_reg;
        want_mask_next     = want_mask_reg;
        timeout_next       = timeout_reg;
        res_kind_next      = res_kind_reg;
        res_frame_next     = res_frame_reg;
        res_present_next   = res_present_reg;
        rsp_kind_next      = rsp_kind_reg;
        rsp_frame_next     = rsp_frame_reg;
        rsp_present_next   = rsp_present_reg;
        rsp_valid_next     = rsp_valid_reg && !rsp.ready;
        ctrl               = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (cmd.mode)
                        MODE_ARRIVE:
                        begin
                            if (arrive_hit)
                            begin
                                waiting_next     = 1'b0;
                                elapsed_next     = '0;
                                res_kind_next    = KIND_FRAME;
                                res_frame_next   = in_frame;
                                res_present_next = 1'b0;
                                state_next       = ST_EMIT;
                            end
                            else
                            begin
                                ctrl.wr_en      = 1'b1;
                                write_slot_next = (write_slot_reg == LAST_SLOT)
                                                  ? '0 : write_slot_reg + 1'b1;
                            end
                        end
                        MODE_REQUEST, MODE_QUERY:
                        begin
                            want_id_next    = cmd.want_id;
                            want_mask_next  = cmd.want_mask;
                            timeout_next    = cmd.wait_ticks;
                            query_next      = (cmd.mode == MODE_QUERY);
                            issue_addr_next = write_slot_reg;
                            issue_cnt_next  = '0;
                            state_next      = ST_SCAN;
                        end
                        MODE_TICK:
                        begin
                            if (waiting_reg)
                            begin
                                elapsed_next = elapsed_inc;
                                if ((pending_limit_reg != 16'd0)
                                    && (elapsed_inc > {1'b0, pending_limit_reg}))
                                begin
                                    waiting_next     = 1'b0;
                                    elapsed_next     = '0;
                                    res_kind_next    = KIND_TIMEOUT;
                                    res_frame_next   = FRAME_ZERO;
                                    res_present_next = 1'b0;
                                    state_next       = ST_EMIT;
                                end
                            end
                        end
                        MODE_CLEAR:
                        begin
                            ctrl.clr_all = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle; compare the slot from the registered read
                if (issue_cnt_reg != SCAN_LEN)
                begin
                    ctrl.rd_en      = 1'b1;
                    chk_valid_next  = 1'b1;
                    chk_addr_next   = issue_addr_reg;
                    chk_last_next   = (issue_cnt_reg == SCAN_LAST);
                    issue_addr_next = (issue_addr_reg == LAST_SLOT)
                                      ? '0 : issue_addr_reg + 1'b1;
                    issue_cnt_next  = issue_cnt_reg + 1'b1;
                end
                if (scan_hit)
                begin
                    chk_valid_next = 1'b0;
                    state_next     = ST_EMIT;
                    if (query_reg)
                    begin
                        res_kind_next    = KIND_AVAIL;
                        res_frame_next   = FRAME_ZERO;
                        res_present_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.clr_one     = 1'b1;
                        res_kind_next    = KIND_FRAME;
                        res_frame_next   = rd_frame;
                        res_present_next = 1'b0;
                    end
                end
                else if (chk_valid_reg && chk_last_reg)
                begin
                    chk_valid_next = 1'b0;
                    if (query_reg)
                    begin
                        res_kind_next    = KIND_AVAIL;
                        res_frame_next   = FRAME_ZERO;
                        res_present_next = 1'b0;
                        state_next       = ST_EMIT;
                    end
                    else
                    begin
                        // no stored match: this read becomes the pending one
                        waiting_next       = 1'b1;
                        pending_id_next    = want_id_reg;
                        pending_mask_next  = want_mask_reg;
                        pending_limit_next = timeout_reg;
                        elapsed_next       = '0;
                        state_next         = ST_IDLE;
                    end
                end
            end

            ST_EMIT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_kind_next    = res_kind_reg;
                    rsp_frame_next   = res_frame_reg;
                    rsp_present_next = res_present_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            write_slot_reg    <= '0;
            waiting_reg       <= 1'b0;
            pending_id_reg    <= '0;
            pending_mask_reg  <= '0;
            pending_limit_reg <= '0;
            elapsed_reg       <= '0;
            issue_addr_reg    <= '0;
            issue_cnt_reg     <= '0;
            chk_valid_reg     <= 1'b0;
            chk_addr_reg      <= '0;
            chk_last_reg      <= 1'b0;
            query_reg         <= 1'b0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            write_slot_reg    <= write_slot_next;
            waiting_reg       <= waiting_next;
            pending_id_reg    <= pending_id_next;
            pending_mask_reg  <= pending_mask_next;
            pending_limit_reg <= pending_limit_next;
            elapsed_reg       <= elapsed_next;
            issue_addr_reg    <= issue_addr_next;
            issue_cnt_reg     <= issue_cnt_next;
            chk_valid_reg     <= chk_valid_next;
            chk_addr_reg      <= chk_addr_next;
            chk_last_reg      <= chk_last_next;
            query_reg         <= query_next;
            rsp_valid_reg     <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_id_reg     <= want_id_next;
        want_mask_reg   <= want_mask_next;
        timeout_reg     <= timeout_next;
        res_kind_reg    <= res_kind_next;
        res_frame_reg   <= res_frame_next;
        res_present_reg <= res_present_next;
        rsp_kind_reg    <= rsp_kind_next;
        rsp_frame_reg   <= rsp_frame_next;
        rsp_present_reg <= rsp_present_next;
    end

endmodule

// ===== sv/canrx_slot_store.sv =====
// Frame slot memory with per-slot valid flags.
module canrx_slot_store #(
    parameter int DEPTH = canrx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  canrx_pkg::slot_ctrl_t    ctrl,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  canrx_pkg::frame_t        wr_frame,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output canrx_pkg::frame_t        rd_frame,
    input  logic [$clog2(DEPTH)-1:0] chk_addr,
    output logic                     chk_valid
);
    import canrx_pkg::*;

    frame_t             mem [DEPTH];
    frame_t             rd_frame_reg;
    logic [DEPTH-1:0]   valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_frame;
        end
        if (ctrl.rd_en)
        begin
            rd_frame_reg <= mem[rd_addr];
        end
    end

    // clear-all wins; writes and single clears never share a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.clr_all)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ctrl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.clr_one)
            begin
                valid_reg[chk_addr] <= 1'b0;
            end
        end
    end

    assign rd_frame  = rd_frame_reg;
    assign chk_valid = valid_reg[chk_addr];

endmodule

// ===== sv/canrx_checker.sv =====
// Port-level checks for the CAN receive mailbox, bound to the top level.
module canrx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  kind,
    input logic [31:0] out_id,
    input logic [3:0]  out_len,
    input logic [63:0] out_data,
    input logic        present
);
    import canrx_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(out_id)
                                    && $stable(out_data) && $stable(present))
        else $error("stalled result changed");

    a_present_only_avail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (kind != KIND_AVAIL) |-> !present)
        else $error("present set on a non-availability result");

    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (kind == KIND_TIMEOUT)
        |-> (out_id == 32'd0) && (out_len == 4'd0) && (out_data == 64'd0))
        else $error("timeout result carries a frame");

    a_avail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (kind == KIND_AVAIL)
        |-> (out_id == 32'd0) && (out_len == 4'd0) && (out_data == 64'd0))
        else $error("availability answer carries a frame");

endmodule

bind can_receive_mailbox_with_filter canrx_checker u_canrx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .kind      (rsp.kind),
    .out_id    (rsp.out_id),
    .out_len   (rsp.out_len),
    .out_data  (rsp.out_data),
    .present   (rsp.present)
);

// ===== tb/sv/can_receive_mailbox_with_filter_tb.sv =====
// Self-checking testbench for the CAN receive mailbox with acceptance filter.
module can_receive_mailbox_with_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import canrx_pkg::*;

    localparam int SLOTS = QUEUE_DEPTH_DEF;
    localparam int LONG_HOLD = 300;
    localparam int PHASE_ITEMS = 200;
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] frame_id;
        logic [3:0]  frame_len;
        logic [63:0] frame_data;
        logic [31:0] want_id;
        logic [31:0] want_mask;
        logic [15:0] wait_ticks;
    } mb_cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] id;
        logic [3:0]  len;
        logic [63:0] data;
        logic        present;
    } mb_rsp_t;

    typedef struct packed {
        mb_cmd_t cmd;
        logic    typed;
        mb_rsp_t rsp;
    } plan_row_t;

    localparam mb_rsp_t NO_RSP = '0;

    // Directed rows; typed rows carry the answer, the rest go through the predictor.
    localparam plan_row_t PLAN [25] = '{
        '{'{MODE_QUERY, 32'h0, 4'd0, 64'h0, 32'h0, 32'h0, 16'h0},
            1'b1, '{KIND_AVAIL, 32'h0, 4'd0, 64'h0, 1'b0}},
        '{'{MODE_TICK, 32'h0, 4'd0, 64'h0, 32'h0, 32'h0, 16'h0}, 1'b0, NO_RSP},
        '{'{MODE_ARRIVE, 32'hFFFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 16'h0},
            1'b0, NO_RSP},
        '{'{MODE_ARRIVE, 32'h0, 4'd0, 64'h0, 32'h0, 32'h0, 16'h0}, 1'b0, NO_RSP},
        '{'{MODE_ARRIVE, 32'h1234_5678, 4'd15, 64'h0123_4567_89AB_CDEF, 32'h0, 32'h0, 16'h0},
            1'b0, NO_RSP},
        '{'{MODE_QUERY, 32'h0, 4'd0, 64'h0, 32'h1234_5678, 32'hFFFF_FFFF, 16'h0},
            1'b1, '{KIND_AVAIL, 32'h0, 4'd0, 64'h0, 1'b1}},
        // zero mask with a nonzero wanted id never matches
        '{'{MODE_QUERY, 32'h0, 4'd0, 64'h0, 32'hFFFF_FFFF, 32'h0, 16'h0},
            1'b1, '{KIND_AVAIL, 32'h0, 4'd0, 64'h0, 1'b0}},
        // scan starts at the write pointer, so the oldest frame wins
        '{'{MODE_REQUEST, 32'h0, 4'd0, 64'h0, 32'h0, 32'h0, 16'h0},
            1'b1, '{KIND_FRAME, 32'hFFFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0}},
        '{'{MODE_REQUEST, 32'h0, 4'd0, 64'h0, 32'h1234_5678, 32'hFFFF_FFFF, 16'h0},
            1'b1, '{KIND_FRAME, 32'h1234_5678, 4'd15, 64'h0123_4567_89AB_CDEF, 1'b0}},
        '{'{MODE_SPARE_FIRST, 32'hFFFF_FFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 16'hFFFF}, 1'b0, NO_RSP},
        '{'{MODE_SPARE_LAST, 32'h0, 4'd0, 64'h0, 32'h0, 32'h0, 16'h0}, 1'b0, NO_RSP},
        '{'{MODE_REQUEST, 32'h0, 4'd0, 64'h0, 32'h0000_0ABC, 32'h0000_0FFF, 16'd2},
            1'b0, NO_RSP},
        '{'{MODE_TICK, 32'h0, 4'd0, 64'h0, 32'h0, 32'h0, 16'h0}, 1'b0, NO_RSP},
        '{'{MODE_TICK, 32'h0, 4'd0, 64'h0, 32'h0, 32'h0, 16'h0}, 1'b0, NO_RSP},
        '{'{MODE_TICK, 32'h0, 4'd0, 64'h0, 32'h0, 32'h0, 16'h0},
            1'b1, '{KIND_TIMEOUT, 32'h0, 4'd0, 64'h0, 1'b0}},
        '{'{MODE_TICK, 32'h0, 4'd0, 64'h0, 32'h0, 32'h0, 16'h0}, 1'b0, NO_RSP},
        // timeout zero: waits through ticks
        '{'{MODE_REQUEST, 32'h0, 4'd0, 64'h0, 32'h0000_0100, 32'h0000_0700, 16'd0},
            1'b0, NO_RSP},
        '{'{MODE_TICK, 32'h0, 4'd0, 64'h0, 32'h0, 32'h0, 16'h0}, 1'b0, NO_RSP},
        '{'{MODE_ARRIVE, 32'h8000_0155, 4'd3, 64'h0000_0000_00AA_BBCC, 32'h0, 32'h0, 16'h0},
            1'b1, '{KIND_FRAME, 32'h8000_0155, 4'd3, 64'h0000_0000_00AA_BBCC, 1'b0}},
        '{'{MODE_REQUEST, 32'h0, 4'd0, 64'h0, 32'h0000_0200, 32'h0000_0700, 16'd1},
            1'b0, NO_RSP},
        // replaces the waiting read
        '{'{MODE_REQUEST, 32'h0, 4'd0, 64'h0, 32'h0000_0300, 32'h0000_0700, 16'd5},
            1'b0, NO_RSP},
        '{'{MODE_ARRIVE, 32'h0000_0200, 4'd2, 64'h1, 32'h0, 32'h0, 16'h0}, 1'b0, NO_RSP},
        '{'{MODE_CLEAR, 32'h0, 4'd0, 64'h0, 32'h0, 32'h0, 16'h0}, 1'b0, NO_RSP},
        '{'{MODE_QUERY, 32'h0, 4'd0, 64'h0, 32'h0, 32'h0, 16'h0},
            1'b1, '{KIND_AVAIL, 32'h0, 4'd0, 64'h0, 1'b0}},
        // clear kept the waiting read
        '{'{MODE_ARRIVE, 32'h0000_7300, 4'd1, 64'hFF, 32'h0, 32'h0, 16'h0},
            1'b1, '{KIND_FRAME, 32'h0000_7300, 4'd1, 64'hFF, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    canrx_in_if  cmd_if ();
    canrx_out_if rsp_if ();

    can_receive_mailbox_with_filter #(
        .QUEUE_DEPTH(SLOTS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always #6 clk = ~clk;

    // mailbox state as the predictor sees it
    bit [31:0]          slot_id   [SLOTS];
    bit [3:0]           slot_len  [SLOTS];
    bit [63:0]          slot_data [SLOTS];
    bit                 slot_full [SLOTS];
    int                 wr_ptr = 0;
    bit                 read_armed = 1'b0;
    bit [31:0]          armed_id = '0;
    bit [31:0]          armed_mask = '0;
    bit [15:0]          armed_limit = '0;
    bit [ELAPSED_W-1:0] ticks_seen = '0;

    mb_rsp_t awaited_rsps [$];
    bit [31:0] id_pool [8];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_asks = 0;
    int hold_served = 0;
    int hold_left = 0;
    int faults = 0;
    int reqs_sent = 0;
    int n_frames = 0;
    int n_timeouts = 0;
    int n_avail = 0;

    function automatic void mailbox_step(input mb_cmd_t c, output bit made, output mb_rsp_t r);
        int s;
        made = 1'b0;
        r = NO_RSP;
        case (c.mode)
            MODE_ARRIVE:
            begin
                if (read_armed && (c.frame_id & armed_mask) == armed_id)
                begin
                    read_armed = 1'b0;
                    ticks_seen = '0;
                    made = 1'b1;
                    r.kind = KIND_FRAME;
                    r.id = c.frame_id;
                    r.len = c.frame_len;
                    r.data = c.frame_data;
                end
                else
                begin
                    slot_id[wr_ptr] = c.frame_id;
                    slot_len[wr_ptr] = c.frame_len;
                    slot_data[wr_ptr] = c.frame_data;
                    slot_full[wr_ptr] = 1'b1;
                    wr_ptr = (wr_ptr + 1) % SLOTS;
                end
            end
            MODE_REQUEST:
            begin
                for (int i = 0; i < SLOTS && !made; i++)
                begin
                    s = (wr_ptr + i) % SLOTS;
                    if (slot_full[s] && (slot_id[s] & c.want_mask) == c.want_id)
                    begin
                        slot_full[s] = 1'b0;
                        made = 1'b1;
                        r.kind = KIND_FRAME;
                        r.id = slot_id[s];
                        r.len = slot_len[s];
                        r.data = slot_data[s];
                    end
                end
                if (!made)
                begin
                    read_armed = 1'b1;
                    armed_id = c.want_id;
                    armed_mask = c.want_mask;
                    armed_limit = c.wait_ticks;
                    ticks_seen = '0;
                end
            end
            MODE_TICK:
            begin
                if (read_armed)
                begin
                    if (ticks_seen != ELAPSED_MAX)
                        ticks_seen++;
                    if (armed_limit != 0 && ticks_seen > armed_limit)
                    begin
                        read_armed = 1'b0;
                        ticks_seen = '0;
                        made = 1'b1;
                        r.kind = KIND_TIMEOUT;
                    end
                end
            end
            MODE_QUERY:
            begin
                made = 1'b1;
                r.kind = KIND_AVAIL;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_full[i] && (slot_id[i] & c.want_mask) == c.want_id)
                        r.present = 1'b1;
            end
            MODE_CLEAR:
                slot_full = '{default: 1'b0};
            default:
                ;
        endcase
    endfunction

    function automatic bit [31:0] pick_id();
        if ($urandom_range(99) < 80)
            return id_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // Mostly ids from a small pool so reads and arrivals meet each other.
    function automatic mb_cmd_t random_cmd();
        mb_cmd_t c;
        int pick;
        bit [31:0] base;
        pick = $urandom_range(99);
        c.frame_id = pick_id();
        c.frame_len = 4'($urandom_range(15));
        c.frame_data = {$urandom, $urandom};
        case ($urandom_range(4))
            0: c.want_mask = '0;
            1: c.want_mask = '1;
            2: c.want_mask = 32'h0000_07FF;
            3: c.want_mask = 32'h1FFF_FFFF;
            default: c.want_mask = $urandom;
        endcase
        base = pick_id();
        c.want_id = ($urandom_range(99) < 85) ? (base & c.want_mask) : $urandom;
        case ($urandom_range(9))
            0, 1: c.wait_ticks = '0;
            2, 3, 4, 5, 6: c.wait_ticks = 16'($urandom_range(4, 1));
            7, 8: c.wait_ticks = 16'($urandom_range(24, 5));
            default: c.wait_ticks = 16'($urandom);
        endcase
        if (pick < 38)
            c.mode = MODE_ARRIVE;
        else if (pick < 62)
            c.mode = MODE_REQUEST;
        else if (pick < 82)
            c.mode = MODE_TICK;
        else if (pick < 92)
            c.mode = MODE_QUERY;
        else if (pick < 94)
            c.mode = MODE_CLEAR;
        else
            c.mode = 3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
        return c;
    endfunction

    // Returns at the edge where the request was taken, with the predicted result.
    task automatic offer(input mb_cmd_t c, output bit made, output mb_rsp_t r);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.mode       <= c.mode;
        cmd_if.frame_id   <= c.frame_id;
        cmd_if.frame_len  <= c.frame_len;
        cmd_if.frame_data <= c.frame_data;
        cmd_if.want_id    <= c.want_id;
        cmd_if.want_mask  <= c.want_mask;
        cmd_if.wait_ticks <= c.wait_ticks;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        mailbox_step(c, made, r);
        reqs_sent++;
    endtask

    task automatic offer_predicted(input mb_cmd_t c);
        bit made;
        mb_rsp_t r;
        offer(c, made, r);
        if (made)
            awaited_rsps.push_back(r);
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_rsps.size() != 0);
    endtask

    task automatic run_random(input int idle, input int stall, input bit with_hold);
        int counted;
        mb_cmd_t c;
        counted = 0;
        send_idle_pct = idle;
        stall_pct = stall;
        while (counted < PHASE_ITEMS)
        begin
            if (with_hold && counted == PHASE_ITEMS / 2)
                hold_asks++;
            c = random_cmd();
            offer_predicted(c);
            if (c.mode <= MODE_CLEAR)
                counted++;
        end
        drain();
    endtask

    // Result side: random stalls plus the occasional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else if (hold_asks != hold_served)
        begin
            hold_served = hold_asks;
            hold_left = LONG_HOLD;
            rsp_if.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        mb_rsp_t got_rsp;
        mb_rsp_t exp_rsp;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            got_rsp.kind = rsp_if.kind;
            got_rsp.id = rsp_if.out_id;
            got_rsp.len = rsp_if.out_len;
            got_rsp.data = rsp_if.out_data;
            got_rsp.present = rsp_if.present;
            case (got_rsp.kind)
                KIND_FRAME: n_frames++;
                KIND_TIMEOUT: n_timeouts++;
                default: n_avail++;
            endcase
            if (awaited_rsps.size() == 0)
            begin
                $error("unexpected result: kind %0d id %h", got_rsp.kind, got_rsp.id);
                faults++;
            end
            else
            begin
                exp_rsp = awaited_rsps.pop_front();
                if (got_rsp.kind !== exp_rsp.kind)
                begin
                    $error("kind: expected %0d, got %0d", exp_rsp.kind, got_rsp.kind);
                    faults++;
                end
                if (got_rsp.id !== exp_rsp.id)
                begin
                    $error("out_id: expected %h, got %h", exp_rsp.id, got_rsp.id);
                    faults++;
                end
                if (got_rsp.len !== exp_rsp.len)
                begin
                    $error("out_len: expected %h, got %h", exp_rsp.len, got_rsp.len);
                    faults++;
                end
                if (got_rsp.data !== exp_rsp.data)
                begin
                    $error("out_data: expected %h, got %h", exp_rsp.data, got_rsp.data);
                    faults++;
                end
                if (got_rsp.present !== exp_rsp.present)
                begin
                    $error("present: expected %b, got %b", exp_rsp.present, got_rsp.present);
                    faults++;
                end
            end
        end
    end

    initial
    begin
        bit made;
        mb_rsp_t r;
        rst_n             <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.mode       <= MODE_ARRIVE;
        cmd_if.frame_id   <= '0;
        cmd_if.frame_len  <= '0;
        cmd_if.frame_data <= '0;
        cmd_if.want_id    <= '0;
        cmd_if.want_mask  <= '0;
        cmd_if.wait_ticks <= '0;
        // even entries standard 11-bit ids, odd ones extended with a flag bit
        for (int i = 0; i < 8; i++)
            id_pool[i] = (i % 2 == 0) ? ($urandom & 32'h0000_07FF) : ($urandom & 32'h9FFF_FFFF);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
        begin
            offer(PLAN[i].cmd, made, r);
            if (PLAN[i].typed)
                awaited_rsps.push_back(PLAN[i].rsp);
            else if (made)
                awaited_rsps.push_back(r);
        end
        drain();

        run_random(0, 0, 1'b1);
        run_random(60, 0, 1'b0);
        run_random(0, 60, 1'b0);
        run_random(17, 17, 1'b0);

        repeat (SLOTS + 4) @(posedge clk);
        if (awaited_rsps.size() != 0)
        begin
            $error("%0d results never arrived", awaited_rsps.size());
            faults++;
        end
        $display("Sent %0d requests: directed rows, then four random phases.",
                 reqs_sent);
        $display("Checked %0d frames, %0d timeouts, %0d availability answers; %0d long holds.",
                 n_frames, n_timeouts, n_avail, hold_served);
        if (faults == 0)
            $display("can_receive_mailbox_with_filter_tb: done, clean");
        else
            $display("can_receive_mailbox_with_filter_tb: done, errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("can_receive_mailbox_with_filter_tb: done, errors");
        $finish;
    end

endmodule
